FILE: rtl/rloa_pkg.sv
// Shared types and codes for the run-length object accumulator.
`default_nettype none
package rloa_pkg;

   typedef logic [1:0] action_type;

   localparam action_type ACT_ADD   = 2'd0;
   localparam action_type ACT_QUERY = 2'd1;
   localparam action_type ACT_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } rloa_state_type;

endpackage
`default_nettype wire

FILE: rtl/rloa_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none
module rloa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: rtl/run_length_object_accumulator_core.sv
// Top level of the run-length object accumulator: run table walk and statistics.
//
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_stall  | action, pixel_x, pixel_y
//  rsp_    | out       | rsp_valid/rsp_stall  | flags, count, sums, bounding box
//
// An add or query walks the whole run table through the single read port of
// the run RAM, and a finish step then registers the result; the next
// transaction can be accepted in the cycle after that. A clear skips the
// walk and goes straight to the finish step.
// Reset clears the valid bits, the statistics and the control state; the RAM
// itself is never cleared, invalid slots are simply ignored.
// The result sits in an output register, so a new transaction is accepted
// while the previous result is still stalled; the finish step waits for it.
`default_nettype none
module run_length_object_accumulator_core #(
   parameter int MAX_RUNS   = 64,
   parameter int COORD_BITS = 12
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire rloa_pkg::action_type      req_action,
   input  wire logic [COORD_BITS-1:0]     req_pixel_x,
   input  wire logic [COORD_BITS-1:0]     req_pixel_y,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic                           rsp_was_added,
   output logic                           rsp_in_object,
   output logic                           rsp_table_full,
   output logic [2*COORD_BITS:0]          rsp_pixel_count,
   output logic [3*COORD_BITS-1:0]        rsp_sum_of_x,
   output logic [3*COORD_BITS-1:0]        rsp_sum_of_y,
   output logic [COORD_BITS-1:0]          rsp_least_x,
   output logic [COORD_BITS-1:0]          rsp_greatest_x,
   output logic [COORD_BITS-1:0]          rsp_least_y,
   output logic [COORD_BITS-1:0]          rsp_greatest_y
);
   import rloa_pkg::*;

   localparam int CB   = COORD_BITS;
   localparam int LW   = CB + 1;            // run length, holds a full row
   localparam int IW   = $clog2(MAX_RUNS);  // slot index
   localparam int CW   = IW + 1;            // read counter, reaches MAX_RUNS
   localparam int NW   = 2 * CB + 1;        // pixel count
   localparam int SW   = 3 * CB;            // coordinate sums
   localparam int EW   = CB + CB + LW;      // RAM entry: row, start, length
   localparam logic [NW-1:0] COUNT_MAX = NW'(1) << (2 * CB);

   // ---------------------------------------------------------------- state
   rloa_state_type state_ff, state_in;

   action_type        act_ff;
   logic [CB-1:0]     x_ff, y_ff;

   logic [CW-1:0]     rd_cnt_ff;
   logic              p_vld_ff;
   logic [IW-1:0]     p_idx_ff;

   // Scan findings. Runs in one row never touch each other between
   // transactions, so at most one run ends just left of the pixel and at
   // most one starts just right of it.
   logic              cov_ff;
   logic              l_hit_ff, r_hit_ff, free_hit_ff;
   logic [IW-1:0]     l_idx_ff, r_idx_ff, free_idx_ff;
   logic [CB-1:0]     l_start_ff;
   logic [LW-1:0]     l_len_ff, r_len_ff;

   logic [MAX_RUNS-1:0] valid_ff, valid_in;

   logic [NW-1:0]     count_ff, count_in;
   logic [SW-1:0]     sx_ff, sx_in, sy_ff, sy_in;
   logic [CB-1:0]     minx_ff, minx_in, maxx_ff, maxx_in;
   logic [CB-1:0]     miny_ff, miny_in, maxy_ff, maxy_in;

   logic              rsp_valid_ff, added_ff, inobj_ff, full_ff;

   // ---------------------------------------------------------------- RAM
   logic              rd_en;
   logic [EW-1:0]     rd_data;
   logic              wr_en;
   logic [IW-1:0]     wr_idx, kill_idx;
   logic [EW-1:0]     wr_data;

   rloa_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_RUNS)
   ) u_runs (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_cnt_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------- scan compare
   logic [CB-1:0] e_row, e_start;
   logic [LW-1:0] e_len, x_ext, s_ext;
   logic          e_ok, e_cov, e_left, e_right;

   assign e_row   = rd_data[EW-1 -: CB];
   assign e_start = rd_data[LW +: CB];
   assign e_len   = rd_data[LW-1:0];
   assign x_ext   = {1'b0, x_ff};
   assign s_ext   = {1'b0, e_start};
   assign e_ok    = p_vld_ff && valid_ff[p_idx_ff] && (e_row == y_ff);
   assign e_cov   = (x_ext >= s_ext) && ((x_ext - s_ext) < e_len);
   assign e_left  = (s_ext + e_len) == x_ext;          // run ends at x - 1
   assign e_right = s_ext == (x_ext + LW'(1));         // run starts at x + 1

   assign rd_en = (state_ff == ST_SCAN) && (rd_cnt_ff < CW'(MAX_RUNS));

   // ---------------------------------------------------------------- finish decode
   logic is_add, is_clear, grow, new_run, full, added, fin_go, req_take, scan_end;

   assign is_add   = act_ff == ACT_ADD;
   assign is_clear = act_ff == ACT_CLEAR;
   assign grow     = !cov_ff && (l_hit_ff || r_hit_ff);
   assign new_run  = !cov_ff && !grow && free_hit_ff;
   assign full     = is_add && !cov_ff && !grow && !free_hit_ff;
   assign added    = is_add && (grow || new_run);
   assign fin_go   = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign req_take = req_valid && !req_stall;
   assign scan_end = p_vld_ff && (p_idx_ff == IW'(MAX_RUNS - 1));
   assign wr_en    = fin_go && added;

   // Pick the slot to write; a pixel that bridges two runs merges them into
   // the lower slot and drops the upper one.
   always_comb begin
      wr_idx   = free_idx_ff;
      kill_idx = r_idx_ff;
      wr_data  = {y_ff, x_ff, LW'(1)};
      priority if (l_hit_ff && r_hit_ff) begin
         wr_idx   = (l_idx_ff < r_idx_ff) ? l_idx_ff : r_idx_ff;
         kill_idx = (l_idx_ff < r_idx_ff) ? r_idx_ff : l_idx_ff;
         wr_data  = {y_ff, l_start_ff, l_len_ff + r_len_ff + LW'(1)};
      end else if (l_hit_ff) begin
         wr_idx  = l_idx_ff;
         wr_data = {y_ff, l_start_ff, l_len_ff + LW'(1)};
      end else if (r_hit_ff) begin
         wr_idx  = r_idx_ff;
         wr_data = {y_ff, x_ff, r_len_ff + LW'(1)};
      end else begin
         wr_idx  = free_idx_ff;
      end
   end

   // Account a newly stored pixel, the first one seeding sums and box; a clear zeroes them.
   always_comb begin
      count_in = count_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      minx_in  = minx_ff;
      maxx_in  = maxx_ff;
      miny_in  = miny_ff;
      maxy_in  = maxy_ff;
      priority if (is_clear) begin
         count_in = '0;
         sx_in    = '0;
         sy_in    = '0;
         minx_in  = '0;
         maxx_in  = '0;
         miny_in  = '0;
         maxy_in  = '0;
      end else if (added) begin
         if (count_ff == '0) begin
            sx_in   = SW'(x_ff);
            sy_in   = SW'(y_ff);
            minx_in = x_ff;
            maxx_in = x_ff;
            miny_in = y_ff;
            maxy_in = y_ff;
         end else begin
            sx_in   = sx_ff + SW'(x_ff);
            sy_in   = sy_ff + SW'(y_ff);
            minx_in = (x_ff < minx_ff) ? x_ff : minx_ff;
            maxx_in = (x_ff > maxx_ff) ? x_ff : maxx_ff;
            miny_in = (y_ff < miny_ff) ? y_ff : miny_ff;
            maxy_in = (y_ff > maxy_ff) ? y_ff : maxy_ff;
         end
         if (count_ff < COUNT_MAX) begin
            count_in = count_ff + NW'(1);
         end
      end else begin
         count_in = count_ff;
      end
   end

   // Mark the written slot live and drop the upper half of a merged pair; a clear empties the table.
   always_comb begin
      valid_in = valid_ff;
      if (is_clear) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
         if (l_hit_ff && r_hit_ff) begin
            valid_in[kill_idx] = 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- FSM
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = (req_action == ACT_CLEAR) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (fin_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      if (req_take) begin
         act_ff    <= req_action;
         x_ff      <= req_pixel_x;
         y_ff      <= req_pixel_y;
      end
      p_idx_ff <= rd_cnt_ff[IW-1:0];
      if (e_ok && e_left) begin
         l_idx_ff   <= p_idx_ff;
         l_start_ff <= e_start;
         l_len_ff   <= e_len;
      end
      if (e_ok && e_right) begin
         r_idx_ff <= p_idx_ff;
         r_len_ff <= e_len;
      end
      if (p_vld_ff && !valid_ff[p_idx_ff] && !free_hit_ff) begin
         free_idx_ff <= p_idx_ff;
      end
      if (fin_go) begin
         added_ff <= added;
         full_ff  <= full;
         inobj_ff <= is_add ? !full : (!is_clear && cov_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff    <= '0;
         p_vld_ff     <= 1'b0;
         cov_ff       <= 1'b0;
         l_hit_ff     <= 1'b0;
         r_hit_ff     <= 1'b0;
         free_hit_ff  <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         minx_ff      <= '0;
         maxx_ff      <= '0;
         miny_ff      <= '0;
         maxy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p_vld_ff <= rd_en;
         // Restart the walk and forget the last findings.
         if (req_take) begin
            rd_cnt_ff   <= '0;
            cov_ff      <= 1'b0;
            l_hit_ff    <= 1'b0;
            r_hit_ff    <= 1'b0;
            free_hit_ff <= 1'b0;
         end else begin
            if (rd_en) begin
               rd_cnt_ff <= rd_cnt_ff + CW'(1);
            end
            if (e_ok && e_cov) begin
               cov_ff <= 1'b1;
            end
            if (e_ok && e_left) begin
               l_hit_ff <= 1'b1;
            end
            if (e_ok && e_right) begin
               r_hit_ff <= 1'b1;
            end
            if (p_vld_ff && !valid_ff[p_idx_ff]) begin
               free_hit_ff <= 1'b1;
            end
         end
         if (fin_go) begin
            count_ff <= count_in;
            valid_ff <= valid_in;
            sx_ff    <= sx_in;
            sy_ff    <= sy_in;
            minx_ff  <= minx_in;
            maxx_ff  <= maxx_in;
            miny_ff  <= miny_in;
            maxy_ff  <= maxy_in;
         end
         // Hold the result until taken; a fresh one replaces it.
         if (fin_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- outputs
   // Statistics change only when a new result is loaded, so they drive the
   // result ports directly.
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_was_added   = added_ff;
   assign rsp_in_object   = inobj_ff;
   assign rsp_table_full  = full_ff;
   assign rsp_pixel_count = count_ff;
   assign rsp_sum_of_x    = sx_ff;
   assign rsp_sum_of_y    = sy_ff;
   assign rsp_least_x     = minx_ff;
   assign rsp_greatest_x  = maxx_ff;
   assign rsp_least_y     = miny_ff;
   assign rsp_greatest_y  = maxy_ff;

   // ---------------------------------------------------------------- checks
   a_added_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_was_added && rsp_table_full))
      else $error("add reported both stored and dropped");

   a_added_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_was_added) |-> (rsp_pixel_count != '0) && rsp_in_object)
      else $error("stored pixel missing from count or membership");

   a_new_slot_free: assert property (@(posedge clock) disable iff (reset)
      (wr_en && !l_hit_ff && !r_hit_ff) |-> !valid_ff[wr_idx])
      else $error("new run written over a live slot");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> !rd_en && (rd_cnt_ff == CW'(MAX_RUNS) || is_clear))
      else $error("finish step reached with the table walk incomplete");

endmodule
`default_nettype wire

FILE: sim/rloa_checker.sv
// Checker for the run-length object accumulator: predicts results and compares them.
`timescale 1ns / 1ps
module rloa_checker #(
   parameter int MAX_RUNS   = 64,
   parameter int COORD_BITS = 12
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire rloa_pkg::action_type   req_action,
   input  wire logic [COORD_BITS-1:0]  req_pixel_x,
   input  wire logic [COORD_BITS-1:0]  req_pixel_y,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire logic                   rsp_was_added,
   input  wire logic                   rsp_in_object,
   input  wire logic                   rsp_table_full,
   input  wire logic [2*COORD_BITS:0]  rsp_pixel_count,
   input  wire logic [3*COORD_BITS-1:0] rsp_sum_of_x,
   input  wire logic [3*COORD_BITS-1:0] rsp_sum_of_y,
   input  wire logic [COORD_BITS-1:0]  rsp_least_x,
   input  wire logic [COORD_BITS-1:0]  rsp_greatest_x,
   input  wire logic [COORD_BITS-1:0]  rsp_least_y,
   input  wire logic [COORD_BITS-1:0]  rsp_greatest_y,
   output int                          failures,
   output int                          pending
);
   import rloa_pkg::*;

   localparam int CB = COORD_BITS;

   typedef struct packed {
      logic            was_added;
      logic            in_object;
      logic            table_full;
      logic [2*CB:0]   pixel_count;
      logic [3*CB-1:0] sum_of_x;
      logic [3*CB-1:0] sum_of_y;
      logic [CB-1:0]   least_x;
      logic [CB-1:0]   greatest_x;
      logic [CB-1:0]   least_y;
      logic [CB-1:0]   greatest_y;
   } pixel_report_type;

   logic [CB-1:0] seg_row   [MAX_RUNS];
   logic [CB-1:0] seg_start [MAX_RUNS];
   logic [CB:0]   seg_len   [MAX_RUNS];
   logic          seg_used  [MAX_RUNS];
   pixel_report_type stats;
   pixel_report_type report_queue[$];

   function automatic logic [CB:0] seg_last(int k);
      return seg_start[k] + seg_len[k] - 1;
   endfunction

   function automatic logic pixel_covered(logic [CB-1:0] x, logic [CB-1:0] y);
      for (int k = 0; k < MAX_RUNS; k++)
         if (seg_used[k] && seg_row[k] == y && x >= seg_start[k] &&
             ({1'b0, x} - seg_start[k]) < seg_len[k])
            return 1'b1;
      return 1'b0;
   endfunction

   task automatic empty_object();
      for (int k = 0; k < MAX_RUNS; k++) seg_used[k] = 1'b0;
      stats = '0;
   endtask

   task automatic fuse_first_pair(logic [CB-1:0] y);
      logic [CB:0] lo, hi;
      for (int i = 0; i < MAX_RUNS; i++) begin
         if (!seg_used[i] || seg_row[i] != y) continue;
         for (int j = i + 1; j < MAX_RUNS; j++) begin
            if (!seg_used[j] || seg_row[j] != y) continue;
            if (seg_start[i] > seg_last(j) + 1 || seg_start[j] > seg_last(i) + 1) continue;
            lo = (seg_start[i] < seg_start[j]) ? seg_start[i] : seg_start[j];
            hi = (seg_last(i) > seg_last(j)) ? seg_last(i) : seg_last(j);
            seg_start[i] = lo[CB-1:0];
            seg_len[i] = hi - lo + 1;
            seg_used[j] = 1'b0;
            return;
         end
      end
   endtask

   // Advance the object by one transaction and return the expected report.
   task automatic accumulate_pixel(action_type act, logic [CB-1:0] x, logic [CB-1:0] y,
                                   output pixel_report_type rep);
      logic decided, grown, added, full;
      int k;
      decided = 0; grown = 0; added = 0; full = 0;
      if (act == ACT_ADD) begin
         for (k = 0; k < MAX_RUNS && !decided; k++) begin
            if (!seg_used[k] || seg_row[k] != y) continue;
            if (x >= seg_start[k] && ({1'b0, x} - seg_start[k]) < seg_len[k])
               decided = 1;
            else if ({1'b0, x} + 1 == seg_start[k]) begin
               seg_start[k] = x;
               seg_len[k]++;
               decided = 1; grown = 1;
            end else if ({1'b0, x} == seg_start[k] + seg_len[k]) begin
               seg_len[k]++;
               decided = 1; grown = 1;
            end
         end
         if (grown) begin
            fuse_first_pair(y);
            added = 1;
         end else if (!decided) begin
            for (k = 0; k < MAX_RUNS && seg_used[k]; k++) ;
            if (k < MAX_RUNS) begin
               seg_row[k] = y; seg_start[k] = x; seg_len[k] = 1; seg_used[k] = 1;
               added = 1;
            end else
               full = 1;
         end
         if (added) begin
            if (stats.pixel_count == 0) begin
               stats.sum_of_x = x; stats.sum_of_y = y;
               stats.least_x = x; stats.greatest_x = x;
               stats.least_y = y; stats.greatest_y = y;
            end else begin
               stats.sum_of_x += x; stats.sum_of_y += y;
               if (x < stats.least_x) stats.least_x = x;
               if (x > stats.greatest_x) stats.greatest_x = x;
               if (y < stats.least_y) stats.least_y = y;
               if (y > stats.greatest_y) stats.greatest_y = y;
            end
            if (stats.pixel_count < (1 << (2 * CB))) stats.pixel_count++;
         end
      end else if (act == ACT_CLEAR)
         empty_object();
      rep = stats;
      rep.was_added = added;
      rep.table_full = full;
      rep.in_object = pixel_covered(x, y);
   endtask

   always @(posedge clock) begin
      pixel_report_type want;
      if (reset) begin
         empty_object();
         report_queue.delete();
         failures <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            accumulate_pixel(req_action, req_pixel_x, req_pixel_y, want);
            report_queue.insert(report_queue.size(), want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (report_queue.size() == 0) begin
               $error("result with no transaction outstanding");
               failures <= failures + 1;
            end else begin
               want = report_queue.pop_front();
               if (rsp_was_added !== want.was_added ||
                   rsp_in_object !== want.in_object ||
                   rsp_table_full !== want.table_full ||
                   rsp_pixel_count !== want.pixel_count ||
                   rsp_sum_of_x !== want.sum_of_x || rsp_sum_of_y !== want.sum_of_y ||
                   rsp_least_x !== want.least_x || rsp_greatest_x !== want.greatest_x ||
                   rsp_least_y !== want.least_y || rsp_greatest_y !== want.greatest_y)
                  failures <= failures + 1;
               if (rsp_was_added !== want.was_added)
                  $error("was_added: expected %0d, got %0d", want.was_added, rsp_was_added);
               if (rsp_in_object !== want.in_object)
                  $error("in_object: expected %0d, got %0d", want.in_object, rsp_in_object);
               if (rsp_table_full !== want.table_full)
                  $error("table_full: expected %0d, got %0d", want.table_full, rsp_table_full);
               if (rsp_pixel_count !== want.pixel_count)
                  $error("pixel_count: expected %0d, got %0d", want.pixel_count, rsp_pixel_count);
               if (rsp_sum_of_x !== want.sum_of_x)
                  $error("sum_of_x: expected %0d, got %0d", want.sum_of_x, rsp_sum_of_x);
               if (rsp_sum_of_y !== want.sum_of_y)
                  $error("sum_of_y: expected %0d, got %0d", want.sum_of_y, rsp_sum_of_y);
               if (rsp_least_x !== want.least_x)
                  $error("least_x: expected %0d, got %0d", want.least_x, rsp_least_x);
               if (rsp_greatest_x !== want.greatest_x)
                  $error("greatest_x: expected %0d, got %0d", want.greatest_x, rsp_greatest_x);
               if (rsp_least_y !== want.least_y)
                  $error("least_y: expected %0d, got %0d", want.least_y, rsp_least_y);
               if (rsp_greatest_y !== want.greatest_y)
                  $error("greatest_y: expected %0d, got %0d", want.greatest_y, rsp_greatest_y);
            end
         end
      end
      pending <= report_queue.size();
   end

endmodule

FILE: sim/tb_run_length_object_accumulator_core.sv
// Testbench top for the run-length object accumulator: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module tb_run_length_object_accumulator_core;
   import rloa_pkg::*;

   localparam int MAX_RUNS   = 64;
   localparam int COORD_BITS = 12;
   localparam int CB         = COORD_BITS;
   // Every transaction at its slowest: table walk, sender gaps, receiver stalls.
   localparam int CYCLE_LIMIT = 1750 * (MAX_RUNS + 3) * 8 + 100000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   action_type          req_action = ACT_ADD;
   logic [CB-1:0]       req_pixel_x = '0;
   logic [CB-1:0]       req_pixel_y = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_was_added, rsp_in_object, rsp_table_full;
   logic [2*CB:0]       rsp_pixel_count;
   logic [3*CB-1:0]     rsp_sum_of_x, rsp_sum_of_y;
   logic [CB-1:0]       rsp_least_x, rsp_greatest_x, rsp_least_y, rsp_greatest_y;
   int                  failures, pending;
   int                  cycle_count = 0;
   // Idle percentages for the sender and the receiver, changed per phase.
   int                  send_idle_pct = 0;
   int                  recv_stall_pct = 0;

   always #5 clock = ~clock;

   run_length_object_accumulator_core #(.MAX_RUNS(MAX_RUNS), .COORD_BITS(COORD_BITS)) dut (
      .clock, .reset, .req_valid, .req_stall, .req_action, .req_pixel_x, .req_pixel_y,
      .rsp_valid, .rsp_stall, .rsp_was_added, .rsp_in_object, .rsp_table_full,
      .rsp_pixel_count, .rsp_sum_of_x, .rsp_sum_of_y, .rsp_least_x, .rsp_greatest_x,
      .rsp_least_y, .rsp_greatest_y);

   rloa_checker #(.MAX_RUNS(MAX_RUNS), .COORD_BITS(COORD_BITS)) checker_inst (
      .clock, .reset, .req_valid, .req_stall, .req_action, .req_pixel_x, .req_pixel_y,
      .rsp_valid, .rsp_stall, .rsp_was_added, .rsp_in_object, .rsp_table_full,
      .rsp_pixel_count, .rsp_sum_of_x, .rsp_sum_of_y, .rsp_least_x, .rsp_greatest_x,
      .rsp_least_y, .rsp_greatest_y, .failures, .pending);

   // Randomize the receiver stall every cycle; drop it entirely in quiet phases.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Time out a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Present one transaction, with an optional random gap first, and hold it
   // until the block accepts it. Return on the accepting edge; the next call
   // or the caller drives valid from there.
   task automatic send_pixel(action_type act, logic [CB-1:0] x, logic [CB-1:0] y);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_pixel_x <= x;
      req_pixel_y <= y;
      // Sample the stall mid-cycle, where it has settled for the coming edge.
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
   endtask

   // Pick a random action: mostly adds, some queries, a rare clear or unused code.
   function automatic action_type pick_action();
      int r;
      r = $urandom_range(99);
      if (r < 70) return ACT_ADD;
      if (r < 94) return ACT_QUERY;
      if (r < 97) return ACT_CLEAR;
      return action_type'(3);
   endfunction

   initial begin
      logic [CB-1:0] bx, by;
      int n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty object, extremes, growth both ways, merge, unused action.
      send_pixel(ACT_QUERY, '1, '1);
      send_pixel(ACT_ADD, '0, '0);
      send_pixel(ACT_ADD, '0, '0);
      send_pixel(ACT_ADD, '1, '1);
      send_pixel(ACT_QUERY, '1, '1);
      send_pixel(ACT_ADD, 12'd10, 12'd5);
      send_pixel(ACT_ADD, 12'd12, 12'd5);
      send_pixel(ACT_ADD, 12'd9, 12'd5);
      send_pixel(ACT_ADD, 12'd11, 12'd5);
      send_pixel(ACT_ADD, 12'd13, 12'd5);
      send_pixel(ACT_ADD, 12'd1, 12'd0);
      send_pixel(ACT_ADD, 12'd4094, 12'd4095);
      send_pixel(action_type'(3), 12'd11, 12'd5);
      send_pixel(ACT_QUERY, 12'd8, 12'd5);
      send_pixel(ACT_CLEAR, 12'd11, 12'd5);
      send_pixel(ACT_QUERY, 12'd11, 12'd5);
      // Fill the table with isolated pixels, then overflow it.
      for (int k = 0; k <= MAX_RUNS; k++)
         send_pixel(ACT_ADD, 12'(2 * k), 12'd100);
      send_pixel(ACT_ADD, 12'd2, 12'd101);
      send_pixel(ACT_ADD, 12'd1, 12'd100);
      send_pixel(ACT_ADD, 12'd2, 12'd101);
      send_pixel(ACT_CLEAR, '0, '0);

      // Random phases: clustered pixels so runs grow and merge, plus scattered noise.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            3: begin send_idle_pct = 15; recv_stall_pct = 15; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         n = 0;
         while (n < 330) begin
            bx = CB'($urandom_range(4095 - 40));
            by = CB'($urandom_range(4095 - 8));
            for (int j = 0; j < 20 && n < 330; j++, n++) begin
               if ($urandom_range(9) == 0)
                  send_pixel(pick_action(), CB'($urandom), CB'($urandom));
               else
                  send_pixel(pick_action(), bx + CB'($urandom_range(40)),
                             by + CB'($urandom_range(8)));
            end
            // Empty the object now and then so the table does not stay full.
            if ($urandom_range(3) == 0) send_pixel(ACT_CLEAR, CB'($urandom), CB'($urandom));
         end
      end
      req_valid <= 1'b0;

      send_idle_pct = 0;
      recv_stall_pct = 0;
      while (pending != 0 || checker_inst.report_queue.size() != 0) @(posedge clock);
      repeat (MAX_RUNS + 10) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
